// ----- sv/wwkc_pkg.sv -----
// Package for the whole-word keyword counter: sizes, register map,
// the cell control struct and the separator test.
// No dependencies; every other file of the block depends on it.
package wwkc_pkg;

    localparam int MAX_KEYWORD_BYTES = 8;
    localparam int KEYWORD_BITS      = 8 * MAX_KEYWORD_BYTES;
    localparam int KEY_LEN_W         = 4;
    localparam int COUNT_W           = 32;
    localparam int CELL_IDX_W        = (MAX_KEYWORD_BYTES > 1) ? $clog2(MAX_KEYWORD_BYTES) : 1;
    localparam int APB_DATA_W        = 64;
    localparam int APB_ADDR_W        = 4;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(1);

    // Register index, taken from bit 3 of the byte address (8-byte slots).
    typedef enum logic
    {
        REG_KEYWORD_BYTES  = 1'b0,
        REG_KEYWORD_LENGTH = 1'b1
    } reg_index_t;

    // Control broadcast to every cell in the chain.
    typedef struct packed
    {
        logic advance;  // accepted token byte: shift the prefix flags one cell on
        logic clear;    // token closed: drop all prefix flags
    } cell_ctrl_t;

    function automatic logic is_separator(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_NEWLINE);
    endfunction

endpackage

// ----- sv/wwkc_if.sv -----
// Handshake interfaces for the text input and the count output.
// Depends on wwkc_pkg for the count width.
interface wwkc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wwkc_count_if;
    logic                           valid;
    logic                           ready;
    logic [wwkc_pkg::COUNT_W-1:0]   match_count;

    modport source (output valid, output match_count, input ready);
    modport sink   (input valid, input match_count, output ready);
endinterface

// ----- sv/wwkc_cfg_regs.sv -----
// APB-style register file holding the keyword bytes and keyword length.
// Depends on wwkc_pkg for the register map and widths.
module wwkc_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wwkc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wwkc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wwkc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [wwkc_pkg::KEYWORD_BITS-1:0]    keyword_bytes,
    output logic [wwkc_pkg::KEY_LEN_W-1:0]       keyword_length
);
    import wwkc_pkg::*;

    logic [KEYWORD_BITS-1:0] keyword_bytes_reg;
    logic [KEY_LEN_W-1:0]    keyword_length_reg;
    logic                    wr_en;
    reg_index_t              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keyword_bytes_reg  <= '0;
            keyword_length_reg <= KEY_LEN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_KEYWORD_BYTES:  keyword_bytes_reg  <= pwdata[KEYWORD_BITS-1:0];
                REG_KEYWORD_LENGTH: keyword_length_reg <= pwdata[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_KEYWORD_BYTES:  prdata = APB_DATA_W'(keyword_bytes_reg);
            REG_KEYWORD_LENGTH: prdata = APB_DATA_W'(keyword_length_reg);
            default:            prdata = '0;
        endcase
    end

    assign keyword_bytes  = keyword_bytes_reg;
    assign keyword_length = keyword_length_reg;

endmodule

// ----- sv/wwkc_cell.sv -----
// One cell of the matching chain: holds the flag "the open token is exactly
// i+1 bytes long and equals the first i+1 keyword bytes". Depends on wwkc_pkg.
module wwkc_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  wwkc_pkg::cell_ctrl_t    ctrl,
    input  logic [7:0]              text_byte,
    input  logic [7:0]              key_byte,
    input  logic                    prev_ok,
    output logic                    ok,
    output logic                    ok_adv
);
    import wwkc_pkg::*;

    logic ok_reg;
    logic ok_next;

    // Flag this cell would take if the current byte extends the token.
    assign ok_adv = prev_ok && (text_byte == key_byte);

    always_comb
    begin
        ok_next = ok_reg;
        if (ctrl.clear)
        begin
            ok_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            ok_next = ok_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule

// ----- sv/whole_word_keyword_counter_top.sv -----
// Top level of the whole-word keyword counter: register file, matching chain,
// match counter and output register. Depends on wwkc_pkg, wwkc_if,
// wwkc_cfg_regs and wwkc_cell.
//
// Usage: text bytes arrive on text_in, one byte per transaction, with
// end_of_text marking the final byte of a stream. Tokens are separated by
// space, tab or newline; a token that equals the keyword counts as a match.
// The keyword (up to 8 bytes, first character in the lowest byte) and its
// length are written over the APB port at byte addresses 0 and 8; write them
// only while no stream is in flight.
// Throughput is one byte per cycle while no result is stalled on count_out.
// Each byte is compared in the cell chain, one cell per keyword position,
// in the cycle it is accepted. Only the end_of_text byte produces a result:
// the saturating match count shows on count_out in the cycle after that
// byte is accepted, and the counting state clears for the next stream.
// When count_out is stalled with a result waiting, text_in drops ready until
// the result is taken, then accepts again in the same cycle the result goes.
// Reset clears the count and the chain and sets the keyword to all zero
// bytes with length one.
module whole_word_keyword_counter_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    wwkc_text_if.sink                            text_in,
    wwkc_count_if.source                         count_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wwkc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wwkc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wwkc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import wwkc_pkg::*;

    logic [KEYWORD_BITS-1:0]      keyword_bytes;
    logic [KEY_LEN_W-1:0]         keyword_length;

    logic                         in_acc;
    logic                         byte_is_sep;
    cell_ctrl_t                   ctrl;
    logic [MAX_KEYWORD_BYTES-1:0] chain;
    logic [MAX_KEYWORD_BYTES-1:0] ok_vec;
    logic [MAX_KEYWORD_BYTES-1:0] adv_vec;

    logic                         at_start_reg;
    logic                         at_start_next;
    logic [COUNT_W-1:0]           running_count_reg;
    logic [COUNT_W-1:0]           running_count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [COUNT_W-1:0]           out_count_reg;

    logic                         len_in_range;
    logic [CELL_IDX_W-1:0]        len_idx;
    logic                         close_match;
    logic [COUNT_W-1:0]           count_closed;

    wwkc_cfg_regs u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .keyword_bytes  (keyword_bytes),
        .keyword_length (keyword_length)
    );

    assign text_in.ready = !out_valid_reg || count_out.ready;
    assign in_acc        = text_in.valid && text_in.ready;
    assign byte_is_sep   = is_separator(text_in.text_byte);

    assign ctrl.advance = in_acc && !byte_is_sep;
    assign ctrl.clear   = in_acc && (byte_is_sep || text_in.end_of_text);

    // The first cell sees "token is empty" as its upstream flag.
    assign chain[0] = at_start_reg;

    for (genvar i = 0; i < MAX_KEYWORD_BYTES; i++)
    begin : g_cell
        wwkc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .text_byte (text_in.text_byte),
            .key_byte  (keyword_bytes[8*i +: 8]),
            .prev_ok   (chain[i]),
            .ok        (ok_vec[i]),
            .ok_adv    (adv_vec[i])
        );
        if (i + 1 < MAX_KEYWORD_BYTES)
        begin : g_link
            assign chain[i+1] = ok_vec[i];
        end
    end

    assign len_in_range = (keyword_length >= KEY_LEN_W'(1)) &&
                          (keyword_length <= KEY_LEN_W'(MAX_KEYWORD_BYTES));
    assign len_idx      = CELL_IDX_W'(keyword_length - KEY_LEN_W'(1));

    // A separator closes the token held in the cells; a last token byte
    // closes the token that includes it.
    always_comb
    begin
        close_match = 1'b0;
        if (in_acc && len_in_range)
        begin
            if (byte_is_sep)
            begin
                close_match = ok_vec[len_idx];
            end
            else if (text_in.end_of_text)
            begin
                close_match = adv_vec[len_idx];
            end
        end
    end

    assign count_closed = (close_match && (running_count_reg != '1)) ?
                          running_count_reg + COUNT_W'(1) : running_count_reg;

    always_comb
    begin
        at_start_next      = at_start_reg;
        running_count_next = running_count_reg;
        out_valid_next     = out_valid_reg && !count_out.ready;
        if (in_acc)
        begin
            at_start_next      = byte_is_sep || text_in.end_of_text;
            running_count_next = text_in.end_of_text ? '0 : count_closed;
            if (text_in.end_of_text)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg      <= 1'b1;
            running_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            at_start_reg      <= at_start_next;
            running_count_reg <= running_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && text_in.end_of_text)
        begin
            out_count_reg <= count_closed;
        end
    end

    assign count_out.valid       = out_valid_reg;
    assign count_out.match_count = out_count_reg;

    // A token has a single length, so at most one prefix flag can be set.
    a_one_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(ok_vec))
        else $error("more than one cell holds a prefix match");

    // An empty token cannot hold any prefix match.
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        at_start_reg |-> (ok_vec == '0))
        else $error("prefix flag set while no token is open");

    // The last byte of a stream always leaves a result waiting and clears the count.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && text_in.end_of_text) |=> (out_valid_reg && at_start_reg &&
                                             (running_count_reg == '0)))
        else $error("end of text did not produce a result and clear the count");

    // A waiting result is never overwritten by a new stream end.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !count_out.ready) |-> !in_acc)
        else $error("input accepted while a result is stalled");

endmodule
